FILE: hdl/gdgp_pkg.sv
// Shared constants, codes and the element radius table for the Gaussian density grid block.
// No dependencies; every other file imports this package.
package gdgp_pkg;

  localparam int ATOMS     = 256;
  localparam int ATOM_AW   = $clog2(ATOMS);
  localparam int CNT_W     = ATOM_AW + 1;
  localparam int EXP_DEPTH = 1024;
  localparam int EXP_AW    = $clog2(EXP_DEPTH);
  // t is Q.36 and the table spans 16.0, so t >> (40 - EXP_AW) is the table index
  localparam int EXP_SHIFT = 40 - EXP_AW;
  // series step h = 16 / EXP_DEPTH in Q.32, so term * h >> 32 is a right shift
  localparam int SER_SHIFT = EXP_AW - 4;
  localparam int SER_TERMS = 12;
  localparam int TERM_W    = 18;
  localparam int ACC_W     = TERM_W + CNT_W;
  localparam int ATOM_W    = 3 * 32 + 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [TERM_W-1:0] P_Q16     = TERM_W'(176948);
  localparam logic [39:0]       ALPHA_NUM = 40'd393307800000;
  localparam logic [34:0]       D_CLAMP   = 35'd16777216;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_EVAL  = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_ELEM = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Z   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTOUR = 3'd4;

  // van der Waals radius in hundredths of an angstrom; 0 means no radius known
  function automatic logic [8:0] vdw_radius(input logic [6:0] el);
    logic [8:0] r;
    case (el)
      7'd0:  r = 9'd216;
      7'd1:  r = 9'd110;
      7'd2:  r = 9'd140;
      7'd3:  r = 9'd181;
      7'd4:  r = 9'd153;
      7'd5:  r = 9'd192;
      7'd6:  r = 9'd170;
      7'd7:  r = 9'd155;
      7'd8:  r = 9'd152;
      7'd9:  r = 9'd147;
      7'd10: r = 9'd154;
      7'd11: r = 9'd227;
      7'd12: r = 9'd173;
      7'd13: r = 9'd184;
      7'd14: r = 9'd210;
      7'd15: r = 9'd180;
      7'd16: r = 9'd180;
      7'd17: r = 9'd175;
      7'd18: r = 9'd188;
      7'd19: r = 9'd275;
      7'd20: r = 9'd231;
      7'd31: r = 9'd187;
      7'd32: r = 9'd211;
      7'd33: r = 9'd185;
      7'd34: r = 9'd190;
      7'd35: r = 9'd183;
      7'd36: r = 9'd202;
      7'd37: r = 9'd303;
      7'd38: r = 9'd249;
      7'd49: r = 9'd193;
      7'd50: r = 9'd217;
      7'd51: r = 9'd206;
      7'd52: r = 9'd206;
      7'd53: r = 9'd198;
      7'd54: r = 9'd216;
      7'd55: r = 9'd343;
      7'd56: r = 9'd268;
      7'd81: r = 9'd196;
      7'd82: r = 9'd202;
      7'd83: r = 9'd207;
      7'd84: r = 9'd197;
      7'd85: r = 9'd202;
      7'd86: r = 9'd220;
      7'd87: r = 9'd348;
      7'd88: r = 9'd283;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/gaussian_density_grid_point.sv
// Gaussian density grid point: atom store memory, exp term table memory and evaluation pipeline.
// Depends on gdgp_pkg.
//
// After reset the block builds its exp term table (a 12-term series, then one shift-add
// multiply per entry), during which in_stall stays high; configuration writes are
// taken at any time. Then one item is worked on at a time. A clear or an undefined
// command gives its result in the cycle after acceptance. A load of a known element into
// a store that is not full runs a bit-serial divider for alpha. An evaluate reads one atom
// per cycle from the atom memory through a seven-stage pipeline; a full store holds 256
// atoms.
module gaussian_density_grid_point
  import gdgp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  input  logic signed [31:0]   in_pos_x,
  input  logic signed [31:0]   in_pos_y,
  input  logic signed [31:0]   in_pos_z,
  input  logic [6:0]           in_element,
  input  logic [9:0]           in_grid_i,
  input  logic [9:0]           in_grid_j,
  input  logic [9:0]           in_grid_k,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_density,
  output logic                 out_inside_res,
  output logic [31:0]          out_inside_count,
  output logic [1:0]           out_status
);

  typedef enum logic [3:0] {
    ST_SER, ST_SER_DIV, ST_SER_UPD, ST_TAB, ST_TAB_MUL, ST_TAB_WR,
    ST_IDLE, ST_LOAD_DIV, ST_LOAD_WR, ST_EVAL_SETUP, ST_EVAL
  } state_t;

  // configuration registers
  logic [20:0]        spacing_r;
  logic signed [31:0] org_x_r, org_y_r, org_z_r;
  logic [31:0]        contour_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= 21'd32768;
      org_x_r   <= '0;
      org_y_r   <= '0;
      org_z_r   <= '0;
      contour_r <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SPACING: spacing_r <= cfg_data[20:0];
        CFG_ORG_X:   org_x_r   <= cfg_data;
        CFG_ORG_Y:   org_y_r   <= cfg_data;
        CFG_ORG_Z:   org_z_r   <= cfg_data;
        CFG_CONTOUR: contour_r <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t             state_r;
  logic [CNT_W-1:0]   loaded_r, cnt_r;
  logic [31:0]        total_r;
  logic [3:0]         ser_n_r;
  logic [32:0]        term_r, rser_r, e_r;
  logic [EXP_AW-1:0]  k_r;
  logic [65:0]        mul_a1_r, mul_a2_r, acc1_r, acc2_r;
  logic [32:0]        mul_b_r;
  logic [6:0]         step_r;
  logic [39:0]        div_n_r, div_q_r;
  logic [21:0]        div_d_r, div_rem_r;
  logic [31:0]        x_r, y_r, z_r;
  logic [9:0]         gi_r, gj_r, gk_r;
  logic signed [34:0] px_r, py_r, pz_r;
  logic [ACC_W-1:0]   acc_r;
  logic               out_valid_r, out_inside_r;
  logic [31:0]        out_density_r, out_count_r;
  logic [1:0]         out_status_r;

  // memories
  logic [ATOM_W-1:0] atom_mem [ATOMS];
  logic [ATOM_W-1:0] atom_rd_r;
  logic [TERM_W-1:0] term_mem [EXP_DEPTH];
  logic [TERM_W-1:0] term_rd_r;

  // pipeline
  logic              v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, hit6_r;
  logic [24:0]       dx_r, dy_r, dz_r;
  logic [23:0]       al2_r, al3_r, al4_r;
  logic [49:0]       sqx_r, sqy_r, sqz_r;
  logic [33:0]       d2_r;
  logic [40:0]       pl_r, ph_r;

  logic              accept, atom_re, atom_we, eval_done, t_hit, out_set;
  logic [8:0]        rad;
  logic [17:0]       r2;
  logic [22:0]       rem_sh;
  logic              div_ge;
  logic [22:0]       rem_new;
  logic [57:0]       t_val;
  logic [EXP_AW-1:0] t_idx;
  logic [65:0]       tw_sum, e_sum;
  logic [51:0]       sq_sum;
  logic [31:0]       dens;
  logic [32:0]       total_inc;

  assign in_stall  = !(state_r == ST_IDLE && (!out_valid_r || !out_stall));
  assign accept    = in_valid && !in_stall;
  assign rad       = vdw_radius(in_element);
  assign r2        = rad * rad;
  assign rem_sh    = {div_rem_r, div_n_r[39]};
  assign div_ge    = rem_sh >= {1'b0, div_d_r};
  assign rem_new   = div_ge ? rem_sh - {1'b0, div_d_r} : rem_sh;
  assign tw_sum    = acc1_r + 66'h80000000;
  assign e_sum     = acc2_r + 66'h80000000;
  assign atom_re   = (state_r == ST_EVAL) && (cnt_r != loaded_r);
  assign atom_we   = (state_r == ST_LOAD_WR);
  assign eval_done = (state_r == ST_EVAL) && (cnt_r == loaded_r) &&
                     !(v1_r || v2_r || v3_r || v4_r || v5_r || v6_r);
  assign dens      = 32'(acc_r);
  assign total_inc = {1'b0, total_r} + 33'd1;
  // a result item is ready: immediate commands, a finished load or a finished evaluate
  assign out_set   = (accept && (in_cmd != CMD_EVAL) &&
                      !(in_cmd == CMD_LOAD && rad != '0 && loaded_r != CNT_W'(ATOMS))) ||
                     (state_r == ST_LOAD_WR) || eval_done;

  always_ff @(posedge clk) begin
    if (atom_we) atom_mem[loaded_r[ATOM_AW-1:0]] <= {x_r, y_r, z_r, div_q_r[23:0]};
    if (atom_re) atom_rd_r <= atom_mem[cnt_r[ATOM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_TAB_WR) term_mem[k_r] <= tw_sum[32 +: TERM_W];
    if (v5_r && t_hit) term_rd_r <= term_mem[t_idx];
  end

  function automatic logic [24:0] axis_d(input logic [31:0] a, input logic signed [34:0] p);
    logic signed [34:0] d;
    logic [34:0]        m;
    d = {{3{a[31]}}, a} - p;
    m = d[34] ? 35'(-d) : 35'(d);
    return (m > D_CLAMP) ? 25'(D_CLAMP) : m[24:0];
  endfunction

  assign sq_sum = 52'(sqx_r) + 52'(sqy_r) + 52'(sqz_r);
  assign t_val  = 58'(pl_r) + (58'(ph_r) << 17);
  assign t_hit  = (t_val[57:40] == '0);
  assign t_idx  = t_val[EXP_SHIFT +: EXP_AW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
      v6_r   <= 1'b0;
      hit6_r <= 1'b0;
    end else begin
      v1_r   <= atom_re;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      v5_r   <= v4_r;
      v6_r   <= v5_r;
      hit6_r <= v5_r && t_hit;
    end
    dx_r  <= axis_d(atom_rd_r[119:88], px_r);
    dy_r  <= axis_d(atom_rd_r[87:56], py_r);
    dz_r  <= axis_d(atom_rd_r[55:24], pz_r);
    al2_r <= atom_rd_r[23:0];
    sqx_r <= dx_r * dx_r;
    sqy_r <= dy_r * dy_r;
    sqz_r <= dz_r * dz_r;
    al3_r <= al2_r;
    d2_r  <= sq_sum[49:16];
    al4_r <= al3_r;
    pl_r  <= al4_r * d2_r[16:0];
    ph_r  <= al4_r * d2_r[33:17];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SER;
      loaded_r    <= '0;
      total_r     <= '0;
      ser_n_r     <= 4'd1;
      term_r      <= 33'h100000000;
      rser_r      <= 33'h100000000;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_set) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_SER: begin
          if (ser_n_r == 4'(SER_TERMS + 1)) begin
            e_r     <= 33'h100000000;
            k_r     <= '0;
            state_r <= ST_TAB;
          end else begin
            div_n_r   <= 40'(term_r >> SER_SHIFT);
            div_d_r   <= 22'(ser_n_r);
            div_rem_r <= '0;
            div_q_r   <= '0;
            step_r    <= '0;
            state_r   <= ST_SER_DIV;
          end
        end
        ST_SER_DIV, ST_LOAD_DIV: begin
          div_rem_r <= rem_new[21:0];
          div_q_r   <= {div_q_r[38:0], div_ge};
          div_n_r   <= {div_n_r[38:0], 1'b0};
          step_r    <= step_r + 7'd1;
          if (step_r == 7'd39) state_r <= (state_r == ST_SER_DIV) ? ST_SER_UPD : ST_LOAD_WR;
        end
        ST_SER_UPD: begin
          term_r  <= div_q_r[32:0];
          rser_r  <= ser_n_r[0] ? rser_r - div_q_r[32:0] : rser_r + div_q_r[32:0];
          ser_n_r <= ser_n_r + 4'd1;
          state_r <= ST_SER;
        end
        ST_TAB: begin
          mul_b_r  <= e_r;
          mul_a1_r <= 66'(P_Q16);
          mul_a2_r <= 66'(rser_r);
          acc1_r   <= '0;
          acc2_r   <= '0;
          step_r   <= '0;
          state_r  <= ST_TAB_MUL;
        end
        ST_TAB_MUL: begin
          if (mul_b_r[0]) begin
            acc1_r <= acc1_r + mul_a1_r;
            acc2_r <= acc2_r + mul_a2_r;
          end
          mul_a1_r <= {mul_a1_r[64:0], 1'b0};
          mul_a2_r <= {mul_a2_r[64:0], 1'b0};
          mul_b_r  <= {1'b0, mul_b_r[32:1]};
          step_r   <= step_r + 7'd1;
          if (step_r == 7'd32) state_r <= ST_TAB_WR;
        end
        ST_TAB_WR: begin
          e_r     <= e_sum[64:32];
          k_r     <= k_r + 1'b1;
          state_r <= (k_r == EXP_AW'(EXP_DEPTH - 1)) ? ST_IDLE : ST_TAB;
        end
        ST_IDLE: begin
          if (accept) begin
            out_density_r <= '0;
            out_inside_r  <= 1'b0;
            case (in_cmd)
              CMD_CLEAR: begin
                loaded_r     <= '0;
                total_r      <= '0;
                out_status_r <= STAT_OK;
                out_count_r  <= '0;
              end
              CMD_LOAD: begin
                out_count_r <= total_r;
                if (rad == '0) begin
                  out_status_r <= STAT_BAD_ELEM;
                end else if (loaded_r == CNT_W'(ATOMS)) begin
                  out_status_r <= STAT_FULL;
                end else begin
                  out_status_r <= STAT_OK;
                  x_r          <= in_pos_x;
                  y_r          <= in_pos_y;
                  z_r          <= in_pos_z;
                  div_n_r      <= ALPHA_NUM + {19'b0, r2, 3'b0};
                  div_d_r      <= {r2, 4'b0};
                  div_rem_r    <= '0;
                  div_q_r      <= '0;
                  step_r       <= '0;
                  state_r      <= ST_LOAD_DIV;
                end
              end
              CMD_EVAL: begin
                gi_r    <= in_grid_i;
                gj_r    <= in_grid_j;
                gk_r    <= in_grid_k;
                state_r <= ST_EVAL_SETUP;
              end
              default: begin
                out_status_r <= STAT_OK;
                out_count_r  <= total_r;
              end
            endcase
          end
        end
        ST_LOAD_WR: begin
          loaded_r <= loaded_r + 1'b1;
          state_r  <= ST_IDLE;
        end
        ST_EVAL_SETUP: begin
          px_r    <= 35'(org_x_r) + 35'(spacing_r * gi_r);
          py_r    <= 35'(org_y_r) + 35'(spacing_r * gj_r);
          pz_r    <= 35'(org_z_r) + 35'(spacing_r * gk_r);
          cnt_r   <= '0;
          acc_r   <= '0;
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          if (atom_re) cnt_r <= cnt_r + 1'b1;
          if (hit6_r) acc_r <= acc_r + ACC_W'(term_rd_r);
          if (eval_done) begin
            out_density_r <= dens;
            out_inside_r  <= dens > contour_r;
            out_status_r  <= STAT_OK;
            if (dens > contour_r && total_r != 32'hFFFFFFFF) begin
              total_r     <= total_inc[31:0];
              out_count_r <= total_inc[31:0];
            end else begin
              out_count_r <= total_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_density      = out_density_r;
  assign out_inside_res   = out_inside_r;
  assign out_inside_count = out_count_r;
  assign out_status       = out_status_r;

endmodule

FILE: hdl/gdgp_checker.sv
// Port-level checks for the Gaussian density grid block, bound to the top level.
// Depends on gdgp_pkg.
module gdgp_checker
  import gdgp_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]          cfg_data,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [1:0]           in_cmd,
  input logic signed [31:0]   in_pos_x,
  input logic signed [31:0]   in_pos_y,
  input logic signed [31:0]   in_pos_z,
  input logic [6:0]           in_element,
  input logic [9:0]           in_grid_i,
  input logic [9:0]           in_grid_j,
  input logic [9:0]           in_grid_k,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [31:0]          out_density,
  input logic                 out_inside_res,
  input logic [31:0]          out_inside_count,
  input logic [1:0]           out_status
);

  // a stalled item keeps its density and count
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_density) && $stable(out_inside_count))
    else $error("stalled result changed");

  // error results carry no density
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_density == '0 && !out_inside_res)
    else $error("error result with density");

  // inside means density above the threshold, so the count is nonzero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_res |-> out_density != '0 && out_inside_count != '0)
    else $error("inside result with zero density or count");

  // an accepted clear reports a zero count next
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == CMD_CLEAR |=> out_valid && out_inside_count == '0)
    else $error("clear did not reset count");

endmodule

bind gaussian_density_grid_point gdgp_checker u_gdgp_checker (.*);

FILE: bench/gaussian_density_grid_point_tb.sv
// Self-checking bench for the Gaussian density grid point block: directed and random items,
// a software predictor and an in-order result scoreboard. Depends on gdgp_pkg.
module gaussian_density_grid_point_tb;
  import gdgp_pkg::*;

  localparam logic [1:0] CMD_UNDEF = 2'd3;
  localparam int WDOG_LIMIT = 200000;
  localparam longint CLAMP = 64'sd16777216;
  localparam int EXP_Q_DEPTH = 64;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] x, y, z;
    logic [6:0]  el;
    logic [9:0]  gi, gj, gk;
  } atom_cmd_t;

  typedef struct {
    logic [31:0] dens;
    logic        ins;
    logic [31:0] cnt;
    logic [1:0]  st;
  } density_res_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall;
  logic [1:0] in_cmd;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic [6:0] in_element;
  logic [9:0] in_grid_i, in_grid_j, in_grid_k;
  logic out_valid, out_stall;
  logic [31:0] out_density, out_inside_count;
  logic out_inside_res;
  logic [1:0] out_status;

  gaussian_density_grid_point dut (.*);

  // predictor state
  logic [20:0] spacing_q;
  logic [31:0] org_x, org_y, org_z, contour_q;
  logic [31:0] atom_x[ATOMS], atom_y[ATOMS], atom_z[ATOMS];
  logic [23:0] atom_alpha[ATOMS];
  int unsigned atom_cnt;
  logic [31:0] inside_tot;
  longint unsigned exp_tab[EXP_DEPTH];
  int unsigned radius_tab[89] = '{
    216, 110, 140, 181, 153, 192, 170, 155, 152, 147, 154, 227, 173, 184, 210,
    180, 180, 175, 188, 275, 231, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 187, 211, 185, 190, 183, 202, 303, 249, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 193, 217, 206, 206, 198, 216, 343, 268, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 196, 202, 207, 197, 202, 220, 348, 283};

  // expected result items, in order
  density_res_t expected_q[EXP_Q_DEPTH];
  int exp_wr = 0, exp_rd = 0;
  int errors = 0;
  int n_items = 0, n_results = 0, n_evals = 0, n_inside = 0;
  int send_pct = 0, recv_pct = 0;
  int hold_req = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void build_exp_table();
    longint unsigned h, term, r, e;
    h = (64'd16 << 32) / EXP_DEPTH;
    term = 64'd1 << 32;
    r = term;
    e = 64'd1 << 32;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * h) >> 32) / n;
      if (n % 2 == 1) r -= term;
      else r += term;
    end
    for (int k = 0; k < EXP_DEPTH; k++) begin
      exp_tab[k] = e;
      e = (e * r + (64'd1 << 31)) >> 32;
    end
  endfunction

  function automatic longint grid_coord(logic [31:0] org, logic [9:0] idx);
    return longint'(signed'(org)) + longint'(spacing_q) * longint'(idx);
  endfunction

  function automatic longint unsigned axis_sq(logic [31:0] a, longint p);
    longint d;
    d = longint'(signed'(a)) - p;
    if (d < 0) d = -d;
    if (d > CLAMP) d = CLAMP;
    return longint'(d * d);
  endfunction

  function automatic logic [31:0] density_at(longint px, longint py, longint pz);
    longint unsigned acc, d2, t, idx;
    acc = 0;
    for (int a = 0; a < atom_cnt; a++) begin
      d2 = (axis_sq(atom_x[a], px) + axis_sq(atom_y[a], py) + axis_sq(atom_z[a], pz)) >> 16;
      t = longint'(atom_alpha[a]) * d2;
      if (t >= (64'd16 << 36)) continue;
      idx = (t * EXP_DEPTH) >> 40;
      acc += (64'd176948 * exp_tab[idx] + (64'd1 << 31)) >> 32;
    end
    return (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
  endfunction

  // advance the predictor by one item and return its result
  function automatic density_res_t apply_item(atom_cmd_t it);
    density_res_t r;
    int unsigned rad;
    longint unsigned r2;
    r = '{dens: '0, ins: 1'b0, cnt: '0, st: STAT_OK};
    case (it.cmd)
      CMD_CLEAR: begin
        atom_cnt = 0;
        inside_tot = '0;
      end
      CMD_LOAD: begin
        rad = (it.el < 89) ? radius_tab[it.el] : 0;
        if (rad == 0) r.st = STAT_BAD_ELEM;
        else if (atom_cnt >= ATOMS) r.st = STAT_FULL;
        else begin
          r2 = rad * rad;
          atom_x[atom_cnt] = it.x;
          atom_y[atom_cnt] = it.y;
          atom_z[atom_cnt] = it.z;
          atom_alpha[atom_cnt] = 24'((64'd393307800000 + 8 * r2) / (16 * r2));
          atom_cnt++;
        end
      end
      CMD_EVAL: begin
        r.dens = density_at(grid_coord(org_x, it.gi), grid_coord(org_y, it.gj),
                            grid_coord(org_z, it.gk));
        if (r.dens > contour_q) begin
          r.ins = 1'b1;
          if (inside_tot != 32'hFFFF_FFFF) inside_tot++;
        end
      end
      default: ;
    endcase
    r.cnt = inside_tot;
    return r;
  endfunction

  task automatic send_item(atom_cmd_t it);
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= it.cmd;
    in_pos_x   <= it.x;
    in_pos_y   <= it.y;
    in_pos_z   <= it.z;
    in_element <= it.el;
    in_grid_i  <= it.gi;
    in_grid_j  <= it.gj;
    in_grid_k  <= it.gk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q[exp_wr % EXP_Q_DEPTH] = apply_item(it);
    exp_wr++;
    n_items++;
    if (it.cmd == CMD_EVAL) n_evals++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SPACING: spacing_q = val[20:0];
      CFG_ORG_X:   org_x = val;
      CFG_ORG_Y:   org_y = val;
      CFG_ORG_Z:   org_z = val;
      CFG_CONTOUR: contour_q = val;
      default: ;
    endcase
  endtask

  function automatic atom_cmd_t mk(logic [1:0] cmd);
    atom_cmd_t it;
    it.cmd = cmd;
    it.x = $urandom; it.y = $urandom; it.z = $urandom;
    it.el = 7'($urandom_range(127));
    it.gi = 10'($urandom_range(1023));
    it.gj = 10'($urandom_range(1023));
    it.gk = 10'($urandom_range(1023));
    return it;
  endfunction

  function automatic logic [6:0] known_element();
    logic [6:0] e;
    do e = 7'($urandom_range(88)); while (radius_tab[e] == 0);
    return e;
  endfunction

  // atom near the grid point (gi,gj,gk), within +-spread Q16.16
  function automatic atom_cmd_t atom_near(logic [9:0] gi, logic [9:0] gj, logic [9:0] gk,
                                          int spread);
    atom_cmd_t it;
    it = mk(CMD_LOAD);
    it.el = known_element();
    it.x = 32'(grid_coord(org_x, gi) + $signed($urandom_range(2 * spread)) - spread);
    it.y = 32'(grid_coord(org_y, gj) + $signed($urandom_range(2 * spread)) - spread);
    it.z = 32'(grid_coord(org_z, gk) + $signed($urandom_range(2 * spread)) - spread);
    return it;
  endfunction

  task automatic eval_at(logic [9:0] gi, logic [9:0] gj, logic [9:0] gk);
    atom_cmd_t it;
    it = mk(CMD_EVAL);
    it.gi = gi; it.gj = gj; it.gk = gk;
    send_item(it);
  endtask

  task automatic load_el(logic [6:0] el, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    atom_cmd_t it;
    it = mk(CMD_LOAD);
    it.el = el; it.x = x; it.y = y; it.z = z;
    send_item(it);
  endtask

  task automatic test_directed();
    send_item(mk(CMD_CLEAR));
    eval_at(10'd0, 10'd0, 10'd0);             // empty store
    load_el(7'd0, 32'd0, 32'd0, 32'd0);       // dummy atom
    load_el(7'd1, 32'h0001_0000, 32'd0, 32'd0);
    load_el(7'd88, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    load_el(7'd21, 32'd0, 32'd0, 32'd0);      // no radius
    load_el(7'd89, 32'd0, 32'd0, 32'd0);
    load_el(7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    eval_at(10'd0, 10'd0, 10'd0);
    eval_at(10'd2, 10'd0, 10'd0);
    eval_at(10'd1023, 10'd1023, 10'd1023);
    send_item(mk(CMD_UNDEF));
    eval_at(10'd1, 10'd0, 10'd1);
    send_item(mk(CMD_CLEAR));
    eval_at(10'd0, 10'd0, 10'd0);
  endtask

  task automatic test_config_extremes();
    logic [31:0] orgs[2] = '{32'h8000_0000, 32'h7FFF_FFFF};
    logic [31:0] spc[3] = '{32'd1, 32'h0010_0000, 32'd0};
    for (int s = 0; s < 3; s++) begin
      write_reg(CFG_SPACING, spc[s]);
      write_reg(CFG_ORG_X, orgs[s % 2]);
      write_reg(CFG_ORG_Y, orgs[(s + 1) % 2]);
      write_reg(CFG_ORG_Z, orgs[s % 2]);
      write_reg(CFG_CONTOUR, (s == 0) ? 32'd0 : 32'hFFFF_FFFF);
      send_item(mk(CMD_CLEAR));
      send_item(atom_near(10'd0, 10'd0, 10'd0, 65536));
      send_item(atom_near(10'd1023, 10'd1023, 10'd1023, 65536));
      eval_at(10'd0, 10'd0, 10'd0);
      eval_at(10'd1023, 10'd1023, 10'd1023);
      eval_at(10'd1, 10'd1022, 10'd511);
    end
  endtask

  task automatic test_store_full();
    write_reg(CFG_SPACING, 32'h8000);
    write_reg(CFG_CONTOUR, 32'h10000);
    send_item(mk(CMD_CLEAR));
    for (int a = 0; a < ATOMS; a++) send_item(atom_near(10'd4, 10'd4, 10'd4, 400000));
    send_item(atom_near(10'd4, 10'd4, 10'd4, 1000));   // store full
    load_el(7'd30, 32'd0, 32'd0, 32'd0);               // element checked before fullness
    eval_at(10'd4, 10'd4, 10'd4);
    eval_at(10'd5, 10'd3, 10'd4);
    eval_at(10'd900, 10'd4, 10'd4);
  endtask

  // mostly clear / load a cluster / evaluate around it, with some noise
  task automatic test_random(int n, int sp, int rp);
    int done;
    logic [9:0] ci, cj, ck;
    atom_cmd_t it;
    send_pct = sp;
    recv_pct = rp;
    done = 0;
    while (done < n) begin
      if ($urandom_range(9) == 0) begin
        it = mk(2'($urandom_range(3)));
        send_item(it);
        if (it.cmd != CMD_UNDEF) done++;
        continue;
      end
      ci = 10'($urandom_range(1023));
      cj = 10'($urandom_range(1023));
      ck = 10'($urandom_range(1023));
      if ($urandom_range(3) != 0 || atom_cnt > 100) begin
        send_item(mk(CMD_CLEAR));
        done++;
      end
      repeat ($urandom_range(4) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 8)) begin
        it = atom_near(ci, cj, ck, $urandom_range(1) ? 200000 : 1000000);
        if ($urandom_range(9) == 0) it.el = 7'($urandom_range(127));
        send_item(it);
        done++;
      end
      repeat ($urandom_range(1, 6)) begin
        eval_at(10'(ci + $urandom_range(6) - 3), 10'(cj + $urandom_range(6) - 3),
                10'(ck + $urandom_range(6) - 3));
        done++;
      end
    end
  endtask

  task automatic test_backpressure();
    send_pct = 0;
    recv_pct = 0;
    send_item(mk(CMD_CLEAR));
    repeat (6) send_item(atom_near(10'd7, 10'd7, 10'd7, 100000));
    hold_req = 800;
    repeat (10) eval_at(10'd7, 10'd7, 10'd7);
  endtask

  task automatic random_config();
    write_reg(CFG_SPACING, $urandom);
    write_reg(CFG_ORG_X, $urandom);
    write_reg(CFG_ORG_Y, $urandom);
    write_reg(CFG_ORG_Z, $urandom);
    write_reg(CFG_CONTOUR, $urandom_range(1) ? $urandom_range(32'h30000) : $urandom);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // receiver: random stall, or a long hold when asked
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (!rst_n) out_stall <= 1'b0;
    else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else out_stall <= ($urandom_range(99) < recv_pct);
  end

  // result checker and watchdog
  always @(posedge clk) begin
    density_res_t w;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (exp_wr == exp_rd) begin
        $display("unexpected result item at %0t", $realtime);
        errors++;
      end else begin
        w = expected_q[exp_rd % EXP_Q_DEPTH];
        exp_rd++;
        if (out_density !== w.dens) report("density", out_density, w.dens);
        if (out_inside_res !== w.ins) report("inside_res", 32'(out_inside_res), 32'(w.ins));
        if (out_inside_count !== w.cnt) report("inside_count", out_inside_count, w.cnt);
        if (out_status !== w.st) report("status", 32'(out_status), 32'(w.st));
        if (w.ins) n_inside++;
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WDOG_LIMIT);
      $display("FAIL gaussian_density_grid_point");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_cmd = CMD_CLEAR;
    in_pos_x = '0; in_pos_y = '0; in_pos_z = '0; in_element = '0;
    in_grid_i = '0; in_grid_j = '0; in_grid_k = '0;
    build_exp_table();
    spacing_q = 21'h8000; org_x = '0; org_y = '0; org_z = '0; contour_q = 32'h10000;
    atom_cnt = 0; inside_tot = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_store_full();
    random_config();
    write_reg(CFG_SPACING, 32'h8000);
    test_random(450, 8, 77);
    random_config();
    test_random(450, 77, 8);
    write_reg(CFG_SPACING, $urandom_range(1, 32'h20000));
    write_reg(CFG_CONTOUR, 32'h18000);
    test_random(450, 0, 0);
    test_backpressure();
    drain();
    repeat (300) @(posedge clk);
    $display("covered %0d items (%0d evaluates), %0d results, %0d inside points",
             n_items, n_evals, n_results, n_inside);
    $display("config extremes, full store, bad elements and a long output hold exercised");
    if (errors == 0 && exp_wr == exp_rd) begin
      $display("PASS gaussian_density_grid_point");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, exp_wr - exp_rd);
      $display("FAIL gaussian_density_grid_point");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/gdgp_pkg.sv
hdl/gaussian_density_grid_point.sv
hdl/gdgp_checker.sv
bench/gaussian_density_grid_point_tb.sv
